### sv/pcbp_pkg.sv
`default_nettype none
package pcbp_pkg;

  // Item kinds on the input channel
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_SYMBOL = 2'd1;
  localparam logic [1:0] KIND_FLUSH  = 2'd2;

  // Field widths fixed by the interface
  localparam int SYM_W     = 8;
  localparam int CVAL_W    = 16;
  localparam int CLEN_W    = 5;
  localparam int BYTE_W    = 8;
  localparam int VBITS_W   = 4;
  localparam int PEND_W    = 7;
  localparam int PCNT_W    = 3;

  // One output word
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic [VBITS_W-1:0] valid_bits;
    logic               last;
  } result_t;

endpackage
`default_nettype wire

### sv/pcbp_out_queue.sv
`default_nettype none
// Three-slot result queue. Takes up to two words per cycle, hands out one.
// Slot 0 is always the head; a pop shifts the rest down.
module pcbp_out_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push0,
  input  wire logic             push1,
  input  wire pcbp_pkg::result_t wr0,
  input  wire pcbp_pkg::result_t wr1,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output pcbp_pkg::result_t     head
);
  import pcbp_pkg::*;

  localparam int SLOTS = 3;

  result_t    q [SLOTS];
  result_t    q_next [SLOTS];
  result_t    shifted [SLOTS];
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic [1:0] cnt_left;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign head      = q[0];
  assign pop       = out_valid && out_ready;
  assign cnt_left  = cnt - {1'b0, pop};
  // room for two more words after this cycle's pop
  assign room      = (cnt_left <= 2'd1);

  // shift on pop, then drop new words in behind the survivors
  always_comb begin
    for (int i = 0; i < SLOTS - 1; i++) begin
      shifted[i] = pop ? q[i+1] : q[i];
    end
    shifted[SLOTS-1] = q[SLOTS-1];
    for (int i = 0; i < SLOTS; i++) begin
      q_next[i] = shifted[i];
      if (push0 && cnt_left == 2'(i)) begin
        q_next[i] = wr0;
      end
      if (push1 && 2'(cnt_left + 2'd1) == 2'(i)) begin
        q_next[i] = wr1;
      end
    end
    cnt_next = cnt_left + {1'b0, push0} + {1'b0, push1};
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < SLOTS; i++) begin
      q[i] <= q_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt_next;
    end
  end

endmodule
`default_nettype wire

### sv/prefix_code_bit_packer_top.sv
`default_nettype none
// Prefix code bit packer.
// Input channel (in_valid/in_ready) carries one word per item: a load writes
// a code table entry (code_value, code_length at index symbol), a symbol word
// appends that symbol's code MSB-first to the bit buffer, a flush emits the
// remaining partial byte zero-padded at the low end. Kind 3 is ignored.
// Output channel (out_valid/out_ready) carries packed bytes with valid_bits
// and last (set on the final byte caused by one input word).
// The table read is registered at the edge that accepts the input word, and
// the packing stage writes the result queue when the queue has room; the
// queue's head drives the output channel.
// Throughput: one input word per cycle while the result queue has room; the
// output side moves one byte per cycle.
// Reset clears the bit buffer and marks every table entry as unwritten
// through per-entry valid bits; no clearing pass, the block is ready at once.
// When the receiver stalls, the three-word result queue stops taking words
// once it cannot hold two more, the packing stage holds its word and
// in_ready drops until space returns.
module prefix_code_bit_packer_top #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    kind,
  input  wire logic [pcbp_pkg::SYM_W-1:0]    symbol,
  input  wire logic [pcbp_pkg::CVAL_W-1:0]   code_value,
  input  wire logic [pcbp_pkg::CLEN_W-1:0]   code_length,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pcbp_pkg::BYTE_W-1:0]        out_byte,
  output logic [pcbp_pkg::VBITS_W-1:0]       valid_bits,
  output logic                               last
);
  import pcbp_pkg::*;

  localparam int CODE_W  = (MAX_CODE_LEN < CVAL_W) ? MAX_CODE_LEN : CVAL_W;
  localparam int LEN_W   = $clog2(CODE_W + 1);
  localparam int ENTRY_W = CODE_W + LEN_W;
  localparam int IDX_W   = $clog2(SYMBOL_COUNT);
  localparam int ACC_W   = PEND_W + CODE_W;
  localparam int CNT_W   = $clog2(ACC_W + 1);

  // table storage
  logic [ENTRY_W-1:0] code_mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] entry_valid;

  logic               in_fire;
  logic               in_range;
  logic [IDX_W-1:0]   idx;
  logic [LEN_W-1:0]   ld_len;
  logic [CODE_W-1:0]  ld_mask;
  logic [CODE_W-1:0]  ld_bits;
  logic               ld_we;

  // packing stage registers
  logic               s1_valid;
  logic [1:0]         s1_kind;
  logic               rd_hit;
  logic [ENTRY_W-1:0] rd_entry;
  logic               s1_go;

  logic [PEND_W-1:0]  pending_bits;
  logic [PEND_W-1:0]  pending_bits_next;
  logic [PCNT_W-1:0]  pending_count;
  logic [PCNT_W-1:0]  pending_count_next;

  logic [LEN_W-1:0]   sym_len;
  logic [CODE_W-1:0]  sym_bits;
  logic [ACC_W-1:0]   acc;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   sh0;
  logic [CNT_W-1:0]   sh1;
  logic [1:0]         n_out;
  result_t            r0;
  result_t            r1;
  result_t            head;
  logic               room;
  logic               push0;
  logic               push1;

  assign in_fire  = in_valid && in_ready;
  assign in_range = (32'(symbol) < SYMBOL_COUNT);
  assign idx      = symbol[IDX_W-1:0];

  // load entry: saturate the length, drop code bits above it
  always_comb begin
    if (32'(code_length) > CODE_W) begin
      ld_len = LEN_W'(CODE_W);
    end else begin
      ld_len = LEN_W'(code_length);
    end
    for (int i = 0; i < CODE_W; i++) begin
      ld_mask[i] = (32'(ld_len) > i);
    end
    ld_bits = code_value[CODE_W-1:0] & ld_mask;
  end

  assign ld_we = in_fire && (kind == KIND_LOAD) && in_range;

  always_ff @(posedge clk) begin
    if (ld_we) begin
      code_mem[idx] <= {ld_len, ld_bits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ld_we) begin
      entry_valid[idx] <= 1'b1;
    end
  end

  // table read, registered; a load and a later symbol never collide
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_entry <= code_mem[idx];
      rd_hit   <= entry_valid[idx] && in_range;
      s1_kind  <= kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (room) begin
      s1_valid <= 1'b0;
    end
  end

  assign in_ready = !s1_valid || room;
  assign s1_go    = s1_valid && room;

  // append the code to the pending bits and cut out whole bytes
  always_comb begin
    sym_len  = rd_hit ? rd_entry[ENTRY_W-1:CODE_W] : '0;
    sym_bits = rd_hit ? rd_entry[CODE_W-1:0] : '0;
    acc      = (ACC_W'(pending_bits) << sym_len) | ACC_W'(sym_bits);
    count    = CNT_W'(pending_count) + CNT_W'(sym_len);
    sh0      = CNT_W'(32'(count) - 8);
    sh1      = CNT_W'(32'(count) - 16);

    n_out              = 2'd0;
    r0                 = '0;
    r1                 = '0;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;

    case (s1_kind)
      KIND_SYMBOL: begin
        if (32'(count) >= 16) begin
          n_out = 2'd2;
          r0    = '{out_byte: BYTE_W'(acc >> sh0), valid_bits: VBITS_W'(8), last: 1'b0};
          r1    = '{out_byte: BYTE_W'(acc >> sh1), valid_bits: VBITS_W'(8), last: 1'b1};
        end else if (32'(count) >= 8) begin
          n_out = 2'd1;
          r0    = '{out_byte: BYTE_W'(acc >> sh0), valid_bits: VBITS_W'(8), last: 1'b1};
        end
        pending_count_next = count[PCNT_W-1:0];
        pending_bits_next  = PEND_W'(acc) &
                             PEND_W'((PEND_W'(1) << count[PCNT_W-1:0]) - PEND_W'(1));
      end
      KIND_FLUSH: begin
        if (pending_count != '0) begin
          n_out = 2'd1;
          r0    = '{out_byte:   BYTE_W'(BYTE_W'(pending_bits) <<
                                        (4'd8 - {1'b0, pending_count})),
                    valid_bits: VBITS_W'(pending_count),
                    last:       1'b1};
          pending_bits_next  = '0;
          pending_count_next = '0;
        end
      end
      default: begin
        n_out = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (s1_go) begin
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end
  end

  assign push0 = s1_go && (n_out != 2'd0);
  assign push1 = s1_go && (n_out == 2'd2);

  pcbp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push0     (push0),
    .push1     (push1),
    .wr0       (r0),
    .wr1       (r1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_byte   = head.out_byte;
  assign valid_bits = head.valid_bits;
  assign last       = head.last;

endmodule
`default_nettype wire
